@@ src/oafs_pkg.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha fade sequencer package
// Shared sizes, codes and the queue entry layout of the fade sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package oafs_pkg;

	localparam int QUEUE_DEPTH   = 8;
	localparam int OVERLAY_COUNT = 3;
	localparam int PROFILE_COUNT = 8;

	localparam int PROFILE_REGS  = 8;
	localparam int PROFILE_W     = 26;
	localparam int CFG_INDEX_W   = $clog2(PROFILE_REGS);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OVL_W  = (OVERLAY_COUNT > 1) ? $clog2(OVERLAY_COUNT) : 1;

	localparam logic [PROFILE_W-1:0] PROFILE_RESET = 26'h3000000;

	typedef enum logic {
		KIND_REQUEST = 1'b0,
		KIND_TICK    = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_APPLIED = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0] pidx;
		phase_t     phase;
		logic [7:0] alpha;
	} entry_t;

endpackage

`default_nettype wire

@@ src/overlay_alpha_fade_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha fade sequencer core
// Per-overlay request queues stepping an alpha value towards a profile's end.
// ----------------------------------------------------------------------------
// One word is taken every cycle while the output side keeps up. A word is
// held in an input register, then the queue head or tail of its overlay is
// read, updated and written back, and any result lands in the output
// register. The read-modify-write of the queue state is combinational and
// is written back as the word leaves the input register, which sets
// this rate; a stalled output holds the input register, and the input
// side stalls only when both are full. Profile writes are taken at any
// time and are meant for when the block is idle.
`default_nettype none

module overlay_alpha_fade_sequencer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // profile_index[2:0], overlay_index[4:3]
	input  wire logic        s_tuser,   // kind[0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata,   // overlay[1:0], alpha[9:2]
	output      logic [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [oafs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [oafs_pkg::PROFILE_W-1:0]   cfg_data
);

	logic [oafs_pkg::PROFILE_W-1:0] profile_q [oafs_pkg::PROFILE_REGS];

	logic                valid_s1;
	oafs_pkg::kind_t     kind_s1;
	logic [2:0]          pidx_s1;
	logic [1:0]          ovl_s1;

	logic [oafs_pkg::CNT_W-1:0]  count_q [oafs_pkg::OVERLAY_COUNT];
	logic [oafs_pkg::HEAD_W-1:0] head_q  [oafs_pkg::OVERLAY_COUNT];
	oafs_pkg::entry_t entry_q [oafs_pkg::OVERLAY_COUNT][oafs_pkg::QUEUE_DEPTH];

	logic                out_valid_q;
	logic [1:0]          out_ovl_q;
	logic [7:0]          out_alpha_q;
	oafs_pkg::status_t   out_status_q;

	logic                        fire_s1;
	logic [oafs_pkg::PROFILE_W-1:0] req_prof;
	logic [1:0]                  q_ovl;
	logic                        ovl_ok;
	logic [oafs_pkg::OVL_W-1:0]  ovl_sel;
	logic [oafs_pkg::CNT_W-1:0]  cnt;
	logic [oafs_pkg::HEAD_W-1:0] head;
	logic [oafs_pkg::CNT_W:0]    tail_sum;
	logic [oafs_pkg::HEAD_W-1:0] wr_slot;
	oafs_pkg::entry_t            head_e;
	oafs_pkg::entry_t            wr_e;
	logic [oafs_pkg::PROFILE_W-1:0] tick_prof;
	logic [7:0]                  p_start;
	logic [7:0]                  p_end;
	logic [7:0]                  p_step;
	logic                        push;
	logic                        pop;
	logic                        wr_en;
	logic                        res_valid;
	logic [1:0]                  res_ovl;
	logic [7:0]                  res_alpha;
	oafs_pkg::status_t           res_status;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire_s1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'b0, out_alpha_q, out_ovl_q};
	assign m_tuser   = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < oafs_pkg::PROFILE_REGS; i++) begin
				profile_q[i] <= oafs_pkg::PROFILE_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			profile_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= oafs_pkg::kind_t'(s_tuser);
			pidx_s1 <= s_tdata[2:0];
			ovl_s1  <= s_tdata[4:3];
		end
	end

	always_comb begin
		req_prof = profile_q[pidx_s1];
		q_ovl    = (kind_s1 == oafs_pkg::KIND_TICK) ? ovl_s1 : req_prof[25:24];
		ovl_ok   = {1'b0, q_ovl} < 3'(oafs_pkg::OVERLAY_COUNT);
		ovl_sel  = q_ovl[oafs_pkg::OVL_W-1:0];
		cnt      = '0;
		head     = '0;
		if (ovl_ok) begin
			cnt  = count_q[ovl_sel];
			head = head_q[ovl_sel];
		end
		tail_sum = (oafs_pkg::CNT_W+1)'(head) + (oafs_pkg::CNT_W+1)'(cnt);
		if (tail_sum >= (oafs_pkg::CNT_W+1)'(oafs_pkg::QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (oafs_pkg::CNT_W+1)'(oafs_pkg::QUEUE_DEPTH);
		end
		head_e    = entry_q[ovl_sel][head];
		tick_prof = profile_q[head_e.pidx];
		p_start   = tick_prof[23:16];
		p_end     = tick_prof[15:8];
		p_step    = (tick_prof[7:0] == 8'd0) ? 8'd1 : tick_prof[7:0];

		push       = 1'b0;
		pop        = 1'b0;
		wr_en      = 1'b0;
		wr_slot    = head;
		wr_e       = head_e;
		res_valid  = 1'b0;
		res_ovl    = '0;
		res_alpha  = '0;
		res_status = oafs_pkg::ST_APPLIED;

		if (kind_s1 == oafs_pkg::KIND_REQUEST) begin
			if (4'(pidx_s1) >= 4'(oafs_pkg::PROFILE_COUNT) || !ovl_ok) begin
				res_valid  = 1'b1;
				res_status = oafs_pkg::ST_UNKNOWN;
			end else if (cnt >= oafs_pkg::CNT_W'(oafs_pkg::QUEUE_DEPTH)) begin
				res_valid  = 1'b1;
				res_ovl    = q_ovl;
				res_status = oafs_pkg::ST_FULL;
			end else begin
				push       = 1'b1;
				wr_en      = 1'b1;
				wr_slot    = tail_sum[oafs_pkg::HEAD_W-1:0];
				wr_e.pidx  = pidx_s1;
				wr_e.phase = oafs_pkg::PH_IDLE;
				wr_e.alpha = req_prof[23:16];
			end
		end else if (ovl_ok && cnt != '0) begin
			case (head_e.phase)
				oafs_pkg::PH_IDLE: begin
					wr_e.phase = (p_start == p_end) ? oafs_pkg::PH_DONE : oafs_pkg::PH_RUN;
				end
				oafs_pkg::PH_RUN: begin
					if (p_start > p_end) begin
						if ({1'b0, head_e.alpha} > {1'b0, p_end} + {1'b0, p_step}) begin
							wr_e.alpha = head_e.alpha - p_step;
						end else begin
							wr_e.alpha = p_end;
							wr_e.phase = oafs_pkg::PH_DONE;
						end
					end else if (p_start < p_end) begin
						if ({1'b0, head_e.alpha} + {1'b0, p_step} < {1'b0, p_end}) begin
							wr_e.alpha = head_e.alpha + p_step;
						end else begin
							wr_e.alpha = p_end;
							wr_e.phase = oafs_pkg::PH_DONE;
						end
					end else begin
						wr_e.alpha = p_end;
						wr_e.phase = oafs_pkg::PH_DONE;
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
			if (!pop) begin
				wr_en     = 1'b1;
				res_valid = 1'b1;
				res_ovl   = q_ovl;
				res_alpha = wr_e.alpha;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < oafs_pkg::OVERLAY_COUNT; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else if (fire_s1) begin
			if (push) begin
				count_q[ovl_sel] <= cnt + 1'b1;
			end else if (pop) begin
				count_q[ovl_sel] <= cnt - 1'b1;
				head_q[ovl_sel]  <= (head == oafs_pkg::HEAD_W'(oafs_pkg::QUEUE_DEPTH - 1)) ?
					'0 : head + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && wr_en) begin
			entry_q[ovl_sel][wr_slot] <= wr_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_valid) begin
			out_ovl_q    <= res_ovl;
			out_alpha_q  <= res_alpha;
			out_status_q <= res_status;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= oafs_pkg::CNT_W'(oafs_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && push |=>
		count_q[$past(ovl_sel)] == oafs_pkg::CNT_W'($past(cnt) + 1'b1))
		else $error("accepted request not counted");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == oafs_pkg::ST_UNKNOWN |-> m_tdata == 16'd0)
		else $error("unknown profile result carries data");

	a_applied_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == oafs_pkg::ST_APPLIED |->
		{1'b0, m_tdata[1:0]} < 3'(oafs_pkg::OVERLAY_COUNT))
		else $error("alpha result for missing overlay");

endmodule

`default_nettype wire
